// ----- design/uvsm_pkg.sv -----
package uvsm_pkg;

  localparam int IDX_W = 17;
  localparam int RAD_W = 16;
  localparam int CNT_W = 9;
  localparam int SUM_W = 20;
  localparam int ANG_W = 32;
  localparam int CRD_W = 34;
  localparam int POS_W = 17;
  localparam int NRM_W = 16;
  localparam int CRN_W = 16;
  localparam int REG_W = 16;

  localparam int MQ_DEPTH = 4;
  localparam int OQ_DEPTH = 2;

  localparam logic ACT_VERTEX   = 1'b0;
  localparam logic ACT_TRIANGLE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CFG = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_SEGMENTS = 2'd1;
  localparam logic [1:0] REG_RINGS    = 2'd2;

  localparam logic [RAD_W-1:0] RST_RADIUS   = 16'd256;
  localparam logic [CNT_W-1:0] RST_SEGMENTS = 9'd32;
  localparam logic [CNT_W-1:0] RST_RINGS    = 9'd16;

  typedef enum logic [1:0] {
    RGN_TOP = 2'd0,
    RGN_MID = 2'd1,
    RGN_BOT = 2'd2
  } rgn_t;

  typedef struct packed {
    logic             act;
    logic [1:0]       status;
    logic             pole_top;
    logic             pole_bot;
    logic [CRN_W-1:0] ca;
    logic [CRN_W-1:0] cb;
    logic [CRN_W-1:0] cc;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [ANG_W-1:0] phi;
    logic [ANG_W-1:0] theta;
  } mq_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [NRM_W-1:0] norm_x;
    logic [NRM_W-1:0] norm_y;
    logic [NRM_W-1:0] norm_z;
    logic [CRN_W-1:0] corner_a;
    logic [CRN_W-1:0] corner_b;
    logic [CRN_W-1:0] corner_c;
  } res_t;

endpackage

// ----- design/uvsm_queue.sv -----
module uvsm_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  output logic         empty,
  input  logic         pop,
  output logic [W-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr;
  logic [PW-1:0] rd;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;

  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign rdata   = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wr <= (wr == PW'(DEPTH - 1)) ? '0 : wr + 1'b1;
      end
      if (do_pop) begin
        rd <= (rd == PW'(DEPTH - 1)) ? '0 : rd + 1'b1;
      end
      cnt <= cnt + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr] <= wdata;
    end
  end

endmodule

// ----- design/uvsm_front.sv -----
module uvsm_front import uvsm_pkg::*; #(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  logic             in_action,
  input  logic [IDX_W-1:0] in_index,
  input  logic [RAD_W-1:0] radius,
  input  logic [CNT_W-1:0] segs,
  input  logic [CNT_W-1:0] rings,
  output logic             out_valid,
  output mq_t              out_word
);

  typedef struct packed {
    logic             act;
    logic [1:0]       status;
    logic             pole_top;
    logic             pole_bot;
    rgn_t             rgn;
    logic             par;
    logic [IDX_W-1:0] dvd;
    logic [IDX_W-1:0] quo;
    logic [CNT_W-1:0] rem;
    logic [SUM_W-1:0] last;
    logic [CRN_W-1:0] ca;
    logic [CRN_W-1:0] cb;
    logic [CRN_W-1:0] cc;
    logic [CNT_W-1:0] rp;
    logic [CNT_W-1:0] rt;
    logic [ANG_W-1:0] qp;
    logic [ANG_W-1:0] qt;
  } fr_t;

  localparam int IDIV0 = 2;
  localparam int CRN   = IDIV0 + IDX_W;
  localparam int ADIV0 = CRN + 1;
  localparam int NS    = ADIV0 + ANG_W;

  fr_t             st [NS];
  logic [NS-1:0]   vld;
  fr_t             w0;
  fr_t             c1;
  fr_t             cc;

  // classify stage arithmetic
  logic [CNT_W-1:0]   rm2;
  logic [2*CNT_W-1:0] prod_l;
  logic [SUM_W-1:0]   last;
  logic [SUM_W-1:0]   nvm1;
  logic [SUM_W-1:0]   nv;
  logic [SUM_W-1:0]   nf;
  logic [SUM_W-1:0]   mid2;
  logic [SUM_W-1:0]   ix;
  logic [SUM_W-1:0]   mm;
  logic [SUM_W-1:0]   sz;
  logic               cfg_bad;
  logic               oor;

  // corner stage arithmetic
  logic [CNT_W-1:0]   seg;
  logic [CNT_W:0]     s1;
  logic [CNT_W-1:0]   nxt;
  logic [2*CNT_W-1:0] prod_c;
  logic [SUM_W-1:0]   cur;
  logic [SUM_W-1:0]   nr;
  logic [SUM_W-1:0]   lst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_comb begin
    w0     = '0;
    w0.act = in_action;
    w0.dvd = in_index;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= w0;
    end
  end

  assign rm2     = rings - CNT_W'(2);
  assign prod_l  = rm2 * segs;
  assign last    = SUM_W'(prod_l) + SUM_W'(1);
  assign sz      = SUM_W'(segs);
  assign nvm1    = last + sz;
  assign nv      = nvm1 + SUM_W'(1);
  assign nf      = (nvm1 - SUM_W'(1)) << 1;
  assign mid2    = (last - SUM_W'(1)) << 1;
  assign ix      = SUM_W'(st[0].dvd);
  assign mm      = ix - sz;
  assign cfg_bad = (radius == '0) || (segs < CNT_W'(3)) || (rings < CNT_W'(2)) ||
                   (32'(segs) > 32'(MAX_SEGMENTS)) || (32'(rings) > 32'(MAX_SEGMENTS));
  assign oor     = (st[0].act == ACT_VERTEX) ? (ix >= nv) : (ix >= nf);

  always_comb begin
    c1      = '0;
    c1.act  = st[0].act;
    c1.last = last;
    c1.rgn  = RGN_TOP;
    if (st[0].act == ACT_VERTEX) begin
      c1.pole_top = (ix == '0);
      c1.pole_bot = (ix == nvm1);
      c1.dvd      = st[0].dvd - IDX_W'(1);
    end else begin
      priority if (ix < sz) begin
        c1.rgn = RGN_TOP;
        c1.dvd = st[0].dvd;
      end else if (ix < sz + mid2) begin
        c1.rgn = RGN_MID;
        c1.dvd = IDX_W'(mm >> 1);
        c1.par = mm[0];
      end else begin
        c1.rgn = RGN_BOT;
        c1.dvd = IDX_W'(mm - mid2);
      end
    end
    priority if (cfg_bad) begin
      c1.status = ST_BAD_CFG;
    end else if (oor) begin
      c1.status = ST_RANGE;
    end else begin
      c1.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[1] <= c1;
    end
  end

  // long division of the index by the segment count, one quotient bit a stage
  for (genvar g = 0; g < IDX_W; g++) begin : g_idiv
    fr_t          nx;
    logic [CNT_W:0] r2;
    always_comb begin
      r2 = {st[IDIV0+g-1].rem, st[IDIV0+g-1].dvd[IDX_W-1-g]};
      nx = st[IDIV0+g-1];
      if (r2 >= {1'b0, segs}) begin
        nx.rem              = CNT_W'(r2 - {1'b0, segs});
        nx.quo[IDX_W-1-g]   = 1'b1;
      end else begin
        nx.rem = r2[CNT_W-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st[IDIV0+g] <= nx;
      end
    end
  end

  assign seg    = st[CRN-1].rem;
  assign s1     = {1'b0, seg} + 1'b1;
  assign nxt    = (s1 == {1'b0, segs}) ? '0 : s1[CNT_W-1:0];
  assign prod_c = st[CRN-1].quo[CNT_W-1:0] * segs;
  assign cur    = SUM_W'(prod_c) + SUM_W'(1);
  assign nr     = cur + sz;
  assign lst    = st[CRN-1].last;

  always_comb begin
    cc    = st[CRN-1];
    cc.rp = st[CRN-1].quo[CNT_W-1:0] + CNT_W'(1);
    cc.rt = seg;
    cc.qp = '0;
    cc.qt = '0;
    cc.ca = '0;
    cc.cb = '0;
    cc.cc = '0;
    if (st[CRN-1].act == ACT_TRIANGLE) begin
      unique case (st[CRN-1].rgn)
        RGN_TOP: begin
          cc.cb = CRN_W'(SUM_W'(seg) + SUM_W'(1));
          cc.cc = CRN_W'(SUM_W'(nxt) + SUM_W'(1));
        end
        RGN_MID: begin
          if (!st[CRN-1].par) begin
            cc.ca = CRN_W'(cur + SUM_W'(seg));
            cc.cb = CRN_W'(nr + SUM_W'(seg));
            cc.cc = CRN_W'(cur + SUM_W'(nxt));
          end else begin
            cc.ca = CRN_W'(cur + SUM_W'(nxt));
            cc.cb = CRN_W'(nr + SUM_W'(seg));
            cc.cc = CRN_W'(nr + SUM_W'(nxt));
          end
        end
        RGN_BOT: begin
          cc.ca = CRN_W'(lst + sz);
          cc.cb = CRN_W'(lst + SUM_W'(nxt));
          cc.cc = CRN_W'(lst + SUM_W'(seg));
        end
        default: begin
          cc.ca = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[CRN] <= cc;
    end
  end

  // ring and segment angles: ring * 2^32 / V and seg * 2^32 / S, bit by bit
  for (genvar g = 0; g < ANG_W; g++) begin : g_adiv
    fr_t            nx;
    logic [CNT_W:0] p2;
    logic [CNT_W:0] t2;
    always_comb begin
      p2 = {st[ADIV0+g-1].rp, 1'b0};
      t2 = {st[ADIV0+g-1].rt, 1'b0};
      nx = st[ADIV0+g-1];
      if (p2 >= {1'b0, rings}) begin
        nx.rp             = CNT_W'(p2 - {1'b0, rings});
        nx.qp[ANG_W-1-g]  = 1'b1;
      end else begin
        nx.rp = p2[CNT_W-1:0];
      end
      if (t2 >= {1'b0, segs}) begin
        nx.rt             = CNT_W'(t2 - {1'b0, segs});
        nx.qt[ANG_W-1-g]  = 1'b1;
      end else begin
        nx.rt = t2[CNT_W-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st[ADIV0+g] <= nx;
      end
    end
  end

  assign out_valid = vld[NS-1];

  always_comb begin
    out_word               = '0;
    out_word.meta.act      = st[NS-1].act;
    out_word.meta.status   = st[NS-1].status;
    out_word.meta.pole_top = st[NS-1].pole_top;
    out_word.meta.pole_bot = st[NS-1].pole_bot;
    out_word.meta.ca       = st[NS-1].ca;
    out_word.meta.cb       = st[NS-1].cb;
    out_word.meta.cc       = st[NS-1].cc;
    // halve: ring angle spans half a turn pole to pole
    out_word.phi           = {1'b0, st[NS-1].qp[ANG_W-1:1]};
    out_word.theta         = st[NS-1].qt;
  end

endmodule

// ----- design/uvsm_back.sv -----
module uvsm_back import uvsm_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  mq_t              in_word,
  input  logic [RAD_W-1:0] radius,
  output logic             out_valid,
  output res_t             out_word
);

  typedef struct packed {
    meta_t                   meta;
    logic                    fp;
    logic                    ft;
    logic signed [CRD_W-1:0] xp;
    logic signed [CRD_W-1:0] yp;
    logic signed [CRD_W-1:0] zp;
    logic signed [CRD_W-1:0] xt;
    logic signed [CRD_W-1:0] yt;
    logic signed [CRD_W-1:0] zt;
  } cs_t;

  localparam int N   = CORDIC_STEPS;
  localparam int LAT = N + 6;
  localparam logic signed [CRD_W-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [31:0] POS_LIM  = 32'sd65535;
  localparam logic signed [31:0] NORM_LIM = 32'sd16384;

  function automatic logic [ANG_W-1:0] atan_turn(input int i);
    logic [ANG_W-1:0] r;
    unique case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [31:0] v);
    logic [POS_W-1:0] r;
    if (v > POS_LIM) begin
      r = POS_W'(POS_LIM);
    end else if (v < -POS_LIM) begin
      r = POS_W'(-POS_LIM);
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [NRM_W-1:0] sat_nrm(input logic signed [31:0] v);
    logic [NRM_W-1:0] r;
    if (v > NORM_LIM) begin
      r = NRM_W'(NORM_LIM);
    end else if (v < -NORM_LIM) begin
      r = NRM_W'(-NORM_LIM);
    end else begin
      r = v[NRM_W-1:0];
    end
    return r;
  endfunction

  logic [LAT-1:0] vld;
  cs_t            cs [N+1];
  cs_t            c0;

  logic [ANG_W-1:0] sum_p;
  logic [ANG_W-1:0] sum_t;
  logic [ANG_W-1:0] ap;
  logic [ANG_W-1:0] at;

  meta_t                   e_meta;
  logic signed [CRD_W-1:0] e_cp;
  logic signed [CRD_W-1:0] e_sp;
  logic signed [CRD_W-1:0] e_ct;
  logic signed [CRD_W-1:0] e_st;

  meta_t                   m1_meta;
  logic signed [50:0]      m1_py;
  logic signed [50:0]      m1_rr;
  logic signed [67:0]      m1_nx;
  logic signed [67:0]      m1_nz;
  logic signed [CRD_W-1:0] m1_ny;
  logic signed [CRD_W-1:0] m1_ct;
  logic signed [CRD_W-1:0] m1_st;

  meta_t                   m2_meta;
  logic signed [31:0]      m2_py;
  logic signed [CRD_W-1:0] m2_rr;
  logic signed [31:0]      m2_nx;
  logic signed [31:0]      m2_ny;
  logic signed [31:0]      m2_nz;
  logic signed [CRD_W-1:0] m2_ct;
  logic signed [CRD_W-1:0] m2_st;

  meta_t                   m3_meta;
  logic signed [67:0]      m3_px;
  logic signed [67:0]      m3_pz;
  logic signed [31:0]      m3_py;
  logic signed [31:0]      m3_nx;
  logic signed [31:0]      m3_ny;
  logic signed [31:0]      m3_nz;

  logic signed [16:0]      rs;
  logic signed [50:0]      py_rnd;
  logic signed [50:0]      rr_rnd;
  logic signed [67:0]      nx_rnd;
  logic signed [67:0]      nz_rnd;
  logic signed [CRD_W-1:0] ny_rnd;
  logic signed [67:0]      px_rnd;
  logic signed [67:0]      pz_rnd;
  res_t                    fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // fold each angle into a quarter turn around zero, negate the result if folded
  assign sum_p = in_word.phi + 32'h4000_0000;
  assign sum_t = in_word.theta + 32'h4000_0000;
  assign ap    = sum_p[ANG_W-1] ? (in_word.phi ^ 32'h8000_0000) : in_word.phi;
  assign at    = sum_t[ANG_W-1] ? (in_word.theta ^ 32'h8000_0000) : in_word.theta;

  always_comb begin
    c0      = '0;
    c0.meta = in_word.meta;
    c0.fp   = sum_p[ANG_W-1];
    c0.ft   = sum_t[ANG_W-1];
    c0.xp   = CORDIC_START;
    c0.xt   = CORDIC_START;
    c0.yp   = '0;
    c0.yt   = '0;
    c0.zp   = {{(CRD_W-ANG_W){ap[ANG_W-1]}}, ap};
    c0.zt   = {{(CRD_W-ANG_W){at[ANG_W-1]}}, at};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs[0] <= c0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_rot
    cs_t                     nx;
    logic signed [CRD_W-1:0] xp;
    logic signed [CRD_W-1:0] yp;
    logic signed [CRD_W-1:0] xt;
    logic signed [CRD_W-1:0] yt;
    logic signed [CRD_W-1:0] an;
    always_comb begin
      nx = cs[k];
      xp = cs[k].xp;
      yp = cs[k].yp;
      xt = cs[k].xt;
      yt = cs[k].yt;
      an = {{(CRD_W-ANG_W){1'b0}}, atan_turn(k)};
      if (!cs[k].zp[CRD_W-1]) begin
        nx.xp = xp - (yp >>> k);
        nx.yp = yp + (xp >>> k);
        nx.zp = cs[k].zp - an;
      end else begin
        nx.xp = xp + (yp >>> k);
        nx.yp = yp - (xp >>> k);
        nx.zp = cs[k].zp + an;
      end
      if (!cs[k].zt[CRD_W-1]) begin
        nx.xt = xt - (yt >>> k);
        nx.yt = yt + (xt >>> k);
        nx.zt = cs[k].zt - an;
      end else begin
        nx.xt = xt + (yt >>> k);
        nx.yt = yt - (xt >>> k);
        nx.zt = cs[k].zt + an;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cs[k+1] <= nx;
      end
    end
  end

  assign rs     = signed'({1'b0, radius});
  assign py_rnd = (m1_py + (51'sd1 <<< 29)) >>> 30;
  assign rr_rnd = (m1_rr + (51'sd1 <<< 15)) >>> 16;
  assign nx_rnd = (m1_nx + (68'sd1 <<< 45)) >>> 46;
  assign nz_rnd = (m1_nz + (68'sd1 <<< 45)) >>> 46;
  assign ny_rnd = (e_cp + (34'sd1 <<< 15)) >>> 16;
  assign px_rnd = (m3_px + (68'sd1 <<< 43)) >>> 44;
  assign pz_rnd = (m3_pz + (68'sd1 <<< 43)) >>> 44;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_meta  <= cs[N].meta;
      e_cp    <= cs[N].fp ? -cs[N].xp : cs[N].xp;
      e_sp    <= cs[N].fp ? -cs[N].yp : cs[N].yp;
      e_ct    <= cs[N].ft ? -cs[N].xt : cs[N].xt;
      e_st    <= cs[N].ft ? -cs[N].yt : cs[N].yt;

      m1_meta <= e_meta;
      m1_py   <= rs * e_cp;
      m1_rr   <= rs * e_sp;
      m1_nx   <= e_sp * e_ct;
      m1_nz   <= e_sp * e_st;
      m1_ny   <= ny_rnd;
      m1_ct   <= e_ct;
      m1_st   <= e_st;

      m2_meta <= m1_meta;
      m2_py   <= py_rnd[31:0];
      m2_rr   <= rr_rnd[CRD_W-1:0];
      m2_nx   <= nx_rnd[31:0];
      m2_nz   <= nz_rnd[31:0];
      m2_ny   <= m1_ny[31:0];
      m2_ct   <= m1_ct;
      m2_st   <= m1_st;

      m3_meta <= m2_meta;
      m3_px   <= m2_rr * m2_ct;
      m3_pz   <= m2_rr * m2_st;
      m3_py   <= m2_py;
      m3_nx   <= m2_nx;
      m3_ny   <= m2_ny;
      m3_nz   <= m2_nz;

      out_word <= fin;
    end
  end

  always_comb begin
    fin        = '0;
    fin.status = m3_meta.status;
    if (m3_meta.status == ST_OK) begin
      if (m3_meta.act == ACT_TRIANGLE) begin
        fin.corner_a = m3_meta.ca;
        fin.corner_b = m3_meta.cb;
        fin.corner_c = m3_meta.cc;
      end else if (m3_meta.pole_top) begin
        fin.pos_y  = {1'b0, radius};
        fin.norm_y = NRM_W'(NORM_LIM);
      end else if (m3_meta.pole_bot) begin
        fin.pos_y  = POS_W'(0) - {1'b0, radius};
        fin.norm_y = NRM_W'(-NORM_LIM);
      end else begin
        fin.pos_x  = sat_pos(px_rnd[31:0]);
        fin.pos_y  = sat_pos(m3_py);
        fin.pos_z  = sat_pos(pz_rnd[31:0]);
        fin.norm_x = sat_nrm(m3_nx);
        fin.norm_y = sat_nrm(m3_ny);
        fin.norm_z = sat_nrm(m3_nz);
      end
    end
  end

  assign out_valid = vld[LAT-1];

endmodule

// ----- design/uv_sphere_mesh_generator.sv -----
// Channel   Direction  Handshake          Payload
// request   in         push / full        action, item_index
// result    out        empty / pop        status, pos_*, norm_*, corner_*
// config    in         cfg_wr_en          cfg_index, cfg_wr_data
//
// One request enters per clock and one result leaves per clock in steady state,
// while the result side keeps popping. An accepted request passes through entry
// and classify stages, 17 stages that split the index by the segment count, a
// corner stage, 32 stages that form both angles bit by bit, the middle queue, the
// CORDIC entry and step stages, then five sign, product, rounding and output
// stages to reach the result ports. Reset loads radius 256, 32 segments, 16 rings
// and empties both queues. A stalled result side fills the output and middle queues, then full rises.
module uv_sphere_mesh_generator import uvsm_pkg::*; #(
  parameter int MAX_SEGMENTS = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    action,
  input  logic [IDX_W-1:0]        item_index,
  output logic                    empty,
  input  logic                    pop,
  output logic [1:0]              status,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z,
  output logic signed [NRM_W-1:0] norm_x,
  output logic signed [NRM_W-1:0] norm_y,
  output logic signed [NRM_W-1:0] norm_z,
  output logic [CRN_W-1:0]        corner_a,
  output logic [CRN_W-1:0]        corner_b,
  output logic [CRN_W-1:0]        corner_c,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_index,
  input  logic [REG_W-1:0]        cfg_wr_data
);

  logic [RAD_W-1:0] radius;
  logic [CNT_W-1:0] segs;
  logic [CNT_W-1:0] rings;

  logic fr_adv;
  logic fr_valid;
  mq_t  fr_word;
  logic mq_full;
  logic mq_empty;
  logic mq_pop;
  mq_t  mq_word;
  logic bk_adv;
  logic bk_valid;
  res_t bk_word;
  logic oq_full;
  res_t oq_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RST_RADIUS;
      segs   <= RST_SEGMENTS;
      rings  <= RST_RINGS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RADIUS:   radius <= cfg_wr_data[RAD_W-1:0];
        REG_SEGMENTS: segs   <= cfg_wr_data[CNT_W-1:0];
        REG_RINGS:    rings  <= cfg_wr_data[CNT_W-1:0];
        default:      ;
      endcase
    end
  end

  // front stalls as a whole when the middle queue has no room
  assign fr_adv = ~mq_full;
  assign full   = ~fr_adv;

  uvsm_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (fr_adv),
    .in_valid (push & ~full),
    .in_action(action),
    .in_index (item_index),
    .radius   (radius),
    .segs     (segs),
    .rings    (rings),
    .out_valid(fr_valid),
    .out_word (fr_word)
  );

  uvsm_queue #(
    .W    ($bits(mq_t)),
    .DEPTH(MQ_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (fr_valid & fr_adv),
    .wdata(fr_word),
    .full (mq_full),
    .empty(mq_empty),
    .pop  (mq_pop),
    .rdata(mq_word)
  );

  assign bk_adv = ~oq_full;
  assign mq_pop = bk_adv & ~mq_empty;

  uvsm_back #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .adv      (bk_adv),
    .in_valid (mq_pop),
    .in_word  (mq_word),
    .radius   (radius),
    .out_valid(bk_valid),
    .out_word (bk_word)
  );

  uvsm_queue #(
    .W    ($bits(res_t)),
    .DEPTH(OQ_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (bk_valid & bk_adv),
    .wdata(bk_word),
    .full (oq_full),
    .empty(empty),
    .pop  (pop),
    .rdata(oq_word)
  );

  assign status   = oq_word.status;
  assign pos_x    = oq_word.pos_x;
  assign pos_y    = oq_word.pos_y;
  assign pos_z    = oq_word.pos_z;
  assign norm_x   = oq_word.norm_x;
  assign norm_y   = oq_word.norm_y;
  assign norm_z   = oq_word.norm_z;
  assign corner_a = oq_word.corner_a;
  assign corner_b = oq_word.corner_b;
  assign corner_c = oq_word.corner_c;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && status != ST_OK |-> corner_a == '0 && pos_y == '0 && norm_y == '0)
    else $error("error result carries payload");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> status == ST_OK || status == ST_BAD_CFG || status == ST_RANGE)
    else $error("bad status code");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result queue not empty after reset");

endmodule

// ----- tb/uvsm_checker.sv -----
module uvsm_checker import uvsm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic                    full,
  input  logic                    action,
  input  logic [IDX_W-1:0]        item_index,
  input  logic                    empty,
  input  logic                    pop,
  input  logic [1:0]              status,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic signed [NRM_W-1:0] norm_x,
  input  logic signed [NRM_W-1:0] norm_y,
  input  logic signed [NRM_W-1:0] norm_z,
  input  logic [CRN_W-1:0]        corner_a,
  input  logic [CRN_W-1:0]        corner_b,
  input  logic [CRN_W-1:0]        corner_c,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_index,
  input  logic [REG_W-1:0]        cfg_wr_data,
  output int                      fail_count,
  output int                      pending,
  output int                      words_seen
);

  localparam int STEPS = 16;
  localparam int MAX_SEG = 256;
  localparam longint POS_LIM = 65535;
  localparam longint NRM_LIM = 16384;

  longint unsigned arctan_tbl [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  logic [RAD_W-1:0] radius_q;
  logic [CNT_W-1:0] seg_cnt;
  logic [CNT_W-1:0] ring_cnt;
  res_t mesh_q [$];

  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] a;
    bit flip;
    longint x, y, z, dx, dy;
    a = ang;
    flip = 0;
    x = 652032874;
    y = 0;
    if (32'(a + 32'h4000_0000) >= 32'h8000_0000) begin
      a = a - 32'h8000_0000;
      flip = 1;
    end
    z = longint'($signed(a));
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(arctan_tbl[i]);
      end else begin
        x += dx; y -= dy; z += longint'(arctan_tbl[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic tessellate(input logic act, input logic [IDX_W-1:0] idx, output res_t r);
    longint unsigned sn, vn, nv, nf, mid, a, b, c, k, ring, sg, m, q, band, cur, nr, nxt;
    longint unsigned last;
    longint rad, px, py, pz, nx, ny, nz, cp, sp, ct, st, rr;
    logic [31:0] phi, theta;
    r = '0;
    sn = seg_cnt;
    vn = ring_cnt;
    rad = radius_q;
    if (radius_q == 0 || sn < 3 || vn < 2 || sn > MAX_SEG || vn > MAX_SEG) begin
      r.status = ST_BAD_CFG;
      return;
    end
    nv = (vn - 1) * sn + 2;
    nf = 2 * sn * (vn - 1);
    if (act == ACT_VERTEX) begin
      if (idx >= nv) begin
        r.status = ST_RANGE;
        return;
      end
      if (idx == 0 || idx == nv - 1) begin
        px = 0; pz = 0; nx = 0; nz = 0;
        py = (idx == 0) ? rad : -rad;
        ny = (idx == 0) ? NRM_LIM : -NRM_LIM;
      end else begin
        k = idx - 1;
        ring = k / sn + 1;
        sg = k % sn;
        phi = 32'((ring << 31) / vn);
        theta = 32'((sg << 32) / sn);
        rotate(phi, cp, sp);
        rotate(theta, ct, st);
        py = rshift_round(rad * cp, 30);
        rr = rshift_round(rad * sp, 16);
        px = rshift_round(rr * ct, 44);
        pz = rshift_round(rr * st, 44);
        ny = rshift_round(cp, 16);
        nx = rshift_round(sp * ct, 46);
        nz = rshift_round(sp * st, 46);
      end
      r.pos_x = POS_W'(clip(px, POS_LIM));
      r.pos_y = POS_W'(clip(py, POS_LIM));
      r.pos_z = POS_W'(clip(pz, POS_LIM));
      r.norm_x = NRM_W'(clip(nx, NRM_LIM));
      r.norm_y = NRM_W'(clip(ny, NRM_LIM));
      r.norm_z = NRM_W'(clip(nz, NRM_LIM));
    end else begin
      if (idx >= nf) begin
        r.status = ST_RANGE;
        return;
      end
      mid = 2 * sn * (vn - 2);
      if (idx < sn) begin
        a = 0; b = 1 + idx; c = 1 + (idx + 1) % sn;
      end else if (idx < sn + mid) begin
        m = idx - sn;
        q = m >> 1;
        band = q / sn;
        sg = q % sn;
        nxt = (sg + 1) % sn;
        cur = 1 + band * sn;
        nr = cur + sn;
        if (m[0] == 0) begin
          a = cur + sg; b = nr + sg; c = cur + nxt;
        end else begin
          a = cur + nxt; b = nr + sg; c = nr + nxt;
        end
      end else begin
        sg = idx - sn - mid;
        last = 1 + (vn - 2) * sn;
        a = nv - 1; b = last + (sg + 1) % sn; c = last + sg;
      end
      r.corner_a = CRN_W'(a);
      r.corner_b = CRN_W'(b);
      r.corner_c = CRN_W'(c);
    end
  endtask

  task automatic compare_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  assign pending = mesh_q.size();

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      radius_q <= RST_RADIUS;
      seg_cnt <= RST_SEGMENTS;
      ring_cnt <= RST_RINGS;
      mesh_q.delete();
      fail_count = 0;
      words_seen <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RADIUS: radius_q <= cfg_wr_data;
          REG_SEGMENTS: seg_cnt <= cfg_wr_data[CNT_W-1:0];
          REG_RINGS: ring_cnt <= cfg_wr_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        tessellate(action, item_index, want);
        mesh_q = {mesh_q, want};
      end
      if (pop && !empty) begin
        words_seen <= words_seen + 1;
        if (mesh_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = mesh_q.pop_front();
          compare_field("status", want.status, status);
          compare_field("pos_x", $signed(want.pos_x), pos_x);
          compare_field("pos_y", $signed(want.pos_y), pos_y);
          compare_field("pos_z", $signed(want.pos_z), pos_z);
          compare_field("norm_x", $signed(want.norm_x), norm_x);
          compare_field("norm_y", $signed(want.norm_y), norm_y);
          compare_field("norm_z", $signed(want.norm_z), norm_z);
          compare_field("corner_a", want.corner_a, corner_a);
          compare_field("corner_b", want.corner_b, corner_b);
          compare_field("corner_c", want.corner_c, corner_c);
        end
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  import uvsm_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic action = 0;
  logic [IDX_W-1:0] item_index = '0;
  logic pop = 0;
  logic cfg_wr_en = 0;
  logic [1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wr_data = '0;
  logic full, empty;
  logic [1:0] status;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic signed [NRM_W-1:0] norm_x, norm_y, norm_z;
  logic [CRN_W-1:0] corner_a, corner_b, corner_c;
  int fail_count, pending, words_seen;
  int cycles = 0;
  int sent = 0;
  int cur_segs = 32, cur_rings = 16;
  bit pop_on = 1;
  bit push_hi = 0;

  always #4 clk = ~clk;

  uv_sphere_mesh_generator u_dut (.*);

  uvsm_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("uv_sphere_mesh_generator regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, mostly short, occasionally long
  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
    end else if ($urandom_range(0, 99) < 3) begin
      pop <= 0;
      pop_on <= 0;
    end else if (!pop_on) begin
      pop <= 0;
      pop_on <= ($urandom_range(0, 9) == 0);
    end else begin
      pop <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_word(logic act, logic [IDX_W-1:0] idx);
    int gap;
    push <= 1;
    push_hi = 1;
    action <= act;
    item_index <= idx;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (gap > 0) begin
      push <= 0;
      push_hi = 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] ix, logic [REG_W-1:0] val);
    cfg_wr_en <= 1;
    cfg_index <= ix;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    if (ix == REG_SEGMENTS) cur_segs = int'(val[CNT_W-1:0]);
    if (ix == REG_RINGS) cur_rings = int'(val[CNT_W-1:0]);
    @(posedge clk);
  endtask

  task automatic settle;
    if (push_hi) begin
      push <= 0;
      push_hi = 0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly in-range requests for the current mesh, some out of range or random
  task automatic random_phase(int n);
    int nv, nf, pick;
    logic act;
    logic [IDX_W-1:0] idx;
    nv = (cur_rings - 1) * cur_segs + 2;
    nf = 2 * cur_segs * (cur_rings - 1);
    if (nv < 1) nv = 1;
    if (nf < 1) nf = 1;
    for (int i = 0; i < n; i++) begin
      act = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 19);
      if (pick == 0) idx = IDX_W'($urandom);
      else if (pick == 1) idx = act ? IDX_W'(nf) : IDX_W'(nv);
      else if (pick == 2) idx = act ? IDX_W'(nf - 1) : IDX_W'(nv - 1);
      else idx = act ? IDX_W'($urandom_range(0, nf - 1)) : IDX_W'($urandom_range(0, nv - 1));
      send_word(act, idx);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset mesh, poles, caps, bands, range edges
    send_word(ACT_VERTEX, 0);
    send_word(ACT_VERTEX, 1);
    send_word(ACT_VERTEX, 481);
    send_word(ACT_VERTEX, 482);
    send_word(ACT_VERTEX, '1);
    send_word(ACT_TRIANGLE, 0);
    send_word(ACT_TRIANGLE, 31);
    send_word(ACT_TRIANGLE, 32);
    send_word(ACT_TRIANGLE, 33);
    send_word(ACT_TRIANGLE, 927);
    send_word(ACT_TRIANGLE, 928);
    send_word(ACT_TRIANGLE, 959);
    send_word(ACT_TRIANGLE, 960);
    send_word(ACT_TRIANGLE, '1);
    settle();
    // invalid settings, then an unused register write with a valid minimum mesh
    write_reg(REG_RADIUS, 0);
    send_word(ACT_VERTEX, 5);
    send_word(ACT_TRIANGLE, 5);
    settle();
    write_reg(REG_RADIUS, 16'hFFFF);
    write_reg(REG_SEGMENTS, 2);
    send_word(ACT_VERTEX, 1);
    settle();
    write_reg(REG_SEGMENTS, 257);
    write_reg(REG_RINGS, 1);
    send_word(ACT_TRIANGLE, 1);
    settle();
    write_reg(REG_RINGS, 257);
    write_reg(REG_SEGMENTS, 3);
    send_word(ACT_VERTEX, 1);
    settle();
    write_reg(REG_UNUSED, 16'h1234);
    write_reg(REG_RINGS, 2);
    send_word(ACT_VERTEX, 2);
    settle();
    // random phases over several meshes, extremes included
    random_phase(200);
    settle();
    write_reg(REG_SEGMENTS, 256);
    write_reg(REG_RINGS, 256);
    random_phase(250);
    settle();
    write_reg(REG_RADIUS, 1);
    write_reg(REG_SEGMENTS, 3);
    write_reg(REG_RINGS, 2);
    random_phase(150);
    settle();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_RADIUS, REG_W'($urandom));
      write_reg(REG_SEGMENTS, REG_W'($urandom_range(3, 256)));
      write_reg(REG_RINGS, REG_W'($urandom_range(2, 256)));
      random_phase(150);
      settle();
    end
    write_reg(REG_RADIUS, 256);
    write_reg(REG_SEGMENTS, 32);
    write_reg(REG_RINGS, 16);
    settle();
    $display("covered %0d requests, %0d result words over invalid, minimum,", sent, words_seen);
    $display("maximum and random mesh settings");
    if (fail_count == 0) begin
      $display("uv_sphere_mesh_generator regression: pass");
    end else begin
      $display("uv_sphere_mesh_generator regression: fail");
    end
    $finish;
  end

endmodule
